// File: hw/rtl/tct_pkg.sv
// Shared types, constants and field layout for the TCP connection state tracker.
package tct_pkg;

  // Port widths: tdata is padded up to whole bytes.
  localparam int IN_TDATA_W  = 104;
  localparam int OUT_TDATA_W = 8;
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 16;
  localparam int TIME_W      = 32;
  localparam int ADDR_W      = 32;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_HANDSHAKE_TIMEOUT   = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ESTABLISHED_TIMEOUT = 8'd1;

  // Reset values of the timeouts, in seconds.
  localparam logic [CFG_DATA_W-1:0] HANDSHAKE_TIMEOUT_RST   = 16'd5;
  localparam logic [CFG_DATA_W-1:0] ESTABLISHED_TIMEOUT_RST = 16'd180;

  // Connection phase encoding.
  typedef enum logic [2:0] {
    PH_NONE     = 3'd0,
    PH_SYN_SENT = 3'd1,
    PH_SYN_ACK  = 3'd2,
    PH_ESTAB    = 3'd3,
    PH_CLOSING  = 3'd4
  } phase_t;

  // One classified packet as it waits between the front and back parts.
  typedef struct packed {
    logic [TIME_W-1:0] now;
    logic [ADDR_W-1:0] src;
    logic [ADDR_W-1:0] dst;
    logic              syn;
    logic              ack;
    logic              fin;
    logic              rst;
    logic              plain_syn;
    logic              syn_ack;
    logic [TIME_W-1:0] hs_expiry;
    logic [TIME_W-1:0] est_expiry;
    logic              hs_expired;
  } item_t;

  // Queue occupancy seen by the front and back parts.
  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

endpackage

// File: hw/rtl/tct_front.sv
// Front part: holds the timeouts, unpacks each packet and precomputes its expiry times.
module tct_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  input  logic [tct_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [tct_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              in_tvalid,
  input  logic [tct_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  tct_pkg::q_status_t                q_status,
  output logic                              in_tready,
  output logic                              push,
  output tct_pkg::item_t                    item
);

  logic [tct_pkg::CFG_DATA_W-1:0] hs_timeout_r;
  logic [tct_pkg::CFG_DATA_W-1:0] est_timeout_r;
  logic [tct_pkg::CFG_DATA_W-1:0] hs_timeout_nxt;
  logic [tct_pkg::CFG_DATA_W-1:0] est_timeout_nxt;

  // Register writes; unknown indexes are ignored.
  always_comb begin
    hs_timeout_nxt  = hs_timeout_r;
    est_timeout_nxt = est_timeout_r;
    if (cfg_valid) begin
      case (cfg_index)
        tct_pkg::REG_HANDSHAKE_TIMEOUT:   hs_timeout_nxt  = cfg_data;
        tct_pkg::REG_ESTABLISHED_TIMEOUT: est_timeout_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hs_timeout_r  <= tct_pkg::HANDSHAKE_TIMEOUT_RST;
      est_timeout_r <= tct_pkg::ESTABLISHED_TIMEOUT_RST;
    end else begin
      hs_timeout_r  <= hs_timeout_nxt;
      est_timeout_r <= est_timeout_nxt;
    end
  end

  // Accept whenever the queue has room.
  assign in_tready = !q_status.full;
  assign push      = in_tvalid && !q_status.full;

  // Unpack and classify; the expiry sums wrap modulo 2^32.
  always_comb begin
    item.now        = in_tdata[31:0];
    item.src        = in_tdata[63:32];
    item.dst        = in_tdata[95:64];
    item.syn        = in_tdata[96];
    item.ack        = in_tdata[97];
    item.fin        = in_tdata[98];
    item.rst        = in_tdata[99];
    item.plain_syn  = item.syn && !item.ack;
    item.syn_ack    = item.syn && item.ack;
    item.hs_expiry  = item.now + {16'd0, hs_timeout_r};
    item.est_expiry = item.now + {16'd0, est_timeout_r};
    // A FIN sets the expiry to the handshake sum; this is its expiry check.
    item.hs_expired = (item.hs_expiry <= item.now);
  end

endmodule

// File: hw/rtl/tct_queue.sv
// Two-entry queue that decouples the front part from the back part.
module tct_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  tct_pkg::item_t     wr_item,
  input  logic               pop,
  output tct_pkg::item_t     rd_item,
  output tct_pkg::q_status_t status
);

  tct_pkg::item_t entry_r [2];
  logic           wr_ptr_r;
  logic           rd_ptr_r;
  logic [1:0]     count_r;
  logic           wr_ptr_nxt;
  logic           rd_ptr_nxt;
  logic [1:0]     count_nxt;

  // Pointer and fill bookkeeping.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= wr_item;
    end
  end

  assign rd_item      = entry_r[rd_ptr_r];
  assign status.empty = (count_r == 2'd0);
  assign status.full  = (count_r == 2'd2);

endmodule

// File: hw/rtl/tct_back.sv
// Back part: keeps the connection entry, makes the pass or drop decision and holds the result.
module tct_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  tct_pkg::item_t                  item,
  input  tct_pkg::q_status_t              q_status,
  output logic                            pop,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [tct_pkg::OUT_TDATA_W-1:0] out_tdata
);

  tct_pkg::phase_t                phase_r;
  tct_pkg::phase_t                phase_nxt;
  logic [tct_pkg::TIME_W-1:0]     expiry_r;
  logic [tct_pkg::TIME_W-1:0]     expiry_nxt;
  logic [tct_pkg::ADDR_W-1:0]     server_r;
  logic [tct_pkg::ADDR_W-1:0]     server_nxt;
  logic                           out_valid_r;
  logic                           out_valid_nxt;
  logic                           drop_r;
  logic                           drop_nxt;
  tct_pkg::phase_t                result_phase_r;

  // Phase and expiry after the FIN step, and whether the entry is then expired.
  tct_pkg::phase_t                fin_phase;
  logic [tct_pkg::TIME_W-1:0]     fin_expiry;
  logic                           expired;

  // Take the next item when the result register is free or being emptied.
  assign pop = !q_status.empty && (!out_valid_r || out_tready);

  // Entry update and decision for one packet.
  always_comb begin
    phase_nxt  = phase_r;
    expiry_nxt = expiry_r;
    server_nxt = server_r;
    drop_nxt   = 1'b0;
    if ((phase_r != tct_pkg::PH_CLOSING) && item.fin) begin
      fin_phase  = tct_pkg::PH_CLOSING;
      fin_expiry = item.hs_expiry;
      expired    = item.hs_expired;
    end else begin
      fin_phase  = phase_r;
      fin_expiry = expiry_r;
      expired    = (expiry_r <= item.now);
    end

    if (phase_r == tct_pkg::PH_NONE) begin
      // Empty entry: only a plain SYN opens it.
      if (item.plain_syn) begin
        phase_nxt  = tct_pkg::PH_SYN_SENT;
        expiry_nxt = item.hs_expiry;
        server_nxt = item.dst;
      end else begin
        drop_nxt = 1'b1;
      end
    end else if (item.rst) begin
      phase_nxt  = tct_pkg::PH_CLOSING;
      expiry_nxt = '0;
    end else begin
      phase_nxt  = fin_phase;
      expiry_nxt = fin_expiry;
      if (expired) begin
        // Expired entry: a plain SYN reuses it, keeping the server.
        if (item.plain_syn) begin
          phase_nxt  = tct_pkg::PH_SYN_SENT;
          expiry_nxt = item.hs_expiry;
        end else begin
          drop_nxt = 1'b1;
        end
      end else begin
        case (fin_phase)
          tct_pkg::PH_SYN_SENT: begin
            if (item.syn_ack && (item.src == server_r)) begin
              phase_nxt  = tct_pkg::PH_SYN_ACK;
              expiry_nxt = item.hs_expiry;
            end else begin
              drop_nxt = 1'b1;
            end
          end
          tct_pkg::PH_SYN_ACK: begin
            if (item.syn) begin
              drop_nxt = 1'b1;
            end else begin
              phase_nxt  = tct_pkg::PH_ESTAB;
              expiry_nxt = item.est_expiry;
            end
          end
          tct_pkg::PH_ESTAB: begin
            if (item.syn) begin
              drop_nxt = 1'b1;
            end else begin
              expiry_nxt = item.est_expiry;
            end
          end
          tct_pkg::PH_CLOSING: begin
            drop_nxt = !item.ack && !item.fin;
          end
          default: ;
        endcase
      end
    end

    if (!pop) begin
      phase_nxt  = phase_r;
      expiry_nxt = expiry_r;
      server_nxt = server_r;
    end
    out_valid_nxt = pop || (out_valid_r && !out_tready);
  end

  // Connection entry and result valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= tct_pkg::PH_NONE;
      expiry_r    <= '0;
      server_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      expiry_r    <= expiry_nxt;
      server_r    <= server_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload, loaded with each decision.
  always_ff @(posedge clk) begin
    if (pop) begin
      drop_r         <= drop_nxt;
      result_phase_r <= phase_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, result_phase_r, drop_r};

endmodule

// File: hw/rtl/tcp_connection_state_tracker.sv
// Top level of the TCP connection state tracker: front part, queue, back part.
// Tracks one TCP connection entry (phase, expiry time, server address) and answers
// pass or drop for each packet header, together with the phase after the packet. It
// takes one packet per clock cycle while the queue has room and returns one result
// per packet, in order; a result not taken stalls the back part and then the queue.
// A taken packet waits in the queue and is decided when the back part pops it; its
// result is held in the result register until taken. The back part reads and writes
// the entry for each packet, which sets the rate. The user writes timeouts over the
// cfg port (index 0 handshake timeout, index 1 established timeout) only while no
// packet is in flight, which the block does not enforce; cfg_ready is always high.
module tcp_connection_state_tracker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tct_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [tct_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // Low bit up: now_seconds[31:0], source_addr[31:0], dest_addr[31:0], flag_syn,
  // flag_ack, flag_fin, flag_rst, four zero bits.
  input  logic [tct_pkg::IN_TDATA_W-1:0]    in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // Low bit up: drop, state_after[2:0], four zero bits.
  output logic [tct_pkg::OUT_TDATA_W-1:0]   out_tdata
);

  tct_pkg::item_t     wr_item;
  tct_pkg::item_t     rd_item;
  tct_pkg::q_status_t q_status;
  logic               push;
  logic               pop;

  assign cfg_ready = 1'b1;

  tct_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tdata  (in_tdata),
    .q_status  (q_status),
    .in_tready (in_tready),
    .push      (push),
    .item      (wr_item)
  );

  tct_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_item (wr_item),
    .pop     (pop),
    .rd_item (rd_item),
    .status  (q_status)
  );

  tct_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item       (rd_item),
    .q_status   (q_status),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // The back part never takes from an empty queue.
  a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_status.empty)
    else $error("queue read while empty");

  // A new result only appears after a decision was made.
  a_result_from_pop: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(pop))
    else $error("result appeared without a decision");

  // A result that leaves the entry empty is always a drop.
  a_none_is_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tdata[3:1] == tct_pkg::PH_NONE)) |-> out_tdata[0])
    else $error("packet passed with no connection");

  // The queue is never full and empty at once.
  a_queue_status: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_status.full && q_status.empty))
    else $error("queue status inconsistent");

endmodule

// File: dv/tcp_connection_state_tracker_tb.sv
// Self-checking testbench for the TCP connection state tracker: directed table, random traffic.
`timescale 1ns / 100ps

module tcp_connection_state_tracker_tb;

  localparam int CYCLE_LIMIT = 400000;
  localparam int ITEMS_PER_SETTING = 265;
  localparam logic [tct_pkg::ADDR_W-1:0] ADDR_LO = 32'h0000_0000;
  localparam logic [tct_pkg::ADDR_W-1:0] ADDR_HI = 32'hFFFF_FFFF;

  // Field types used for sized conversions.
  typedef logic [tct_pkg::TIME_W-1:0]      secs_t;
  typedef logic [tct_pkg::CFG_INDEX_W-1:0] cfg_index_t;
  typedef logic [tct_pkg::CFG_DATA_W-1:0]  cfg_data_t;

  // One packet header as the sender sees it.
  typedef struct packed {
    logic [tct_pkg::TIME_W-1:0] now;
    logic [tct_pkg::ADDR_W-1:0] src;
    logic [tct_pkg::ADDR_W-1:0] dst;
    logic                       syn;
    logic                       ack;
    logic                       fin;
    logic                       rst;
  } packet_t;

  // Decision for one packet: pass or drop and the phase afterward.
  typedef struct packed {
    logic       drop;
    logic [2:0] state;
  } verdict_t;

  // A verdict written into the directed table, used when known is set.
  typedef struct packed {
    logic            known;
    logic            drop;
    tct_pkg::phase_t state;
  } given_verdict_t;

  typedef struct packed {
    logic [tct_pkg::TIME_W-1:0] now;
    logic [tct_pkg::ADDR_W-1:0] src;
    logic [tct_pkg::ADDR_W-1:0] dst;
    logic                       syn;
    logic                       ack;
    logic                       fin;
    logic                       rst;
    logic                       known;
    logic                       drop;
    tct_pkg::phase_t            state;
  } directed_row_t;

  // Directed walk with the reset timeouts (handshake 5 s, established 180 s).
  // The server becomes ADDR_HI on the first plain SYN and is never replaced.
  localparam int DIRECTED_ROWS = 25;
  localparam directed_row_t DIRECTED [0:DIRECTED_ROWS-1] = '{
    // Empty entry: only a plain SYN opens it, FIN and RST do not count.
    '{32'd100, ADDR_LO, ADDR_HI, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, tct_pkg::PH_NONE},
    '{32'd100, ADDR_LO, ADDR_HI, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, tct_pkg::PH_NONE},
    '{32'd100, ADDR_LO, ADDR_HI, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, tct_pkg::PH_NONE},
    '{32'd100, ADDR_LO, ADDR_HI, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, tct_pkg::PH_NONE},
    '{32'd100, ADDR_LO, ADDR_HI, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, tct_pkg::PH_SYN_SENT},
    // SYN-ACK from the wrong side, then a bare ACK, then the real SYN-ACK.
    '{32'd101, ADDR_LO, ADDR_HI, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, tct_pkg::PH_SYN_SENT},
    '{32'd101, ADDR_HI, ADDR_LO, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, tct_pkg::PH_SYN_SENT},
    '{32'd102, ADDR_HI, ADDR_LO, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, tct_pkg::PH_SYN_ACK},
    '{32'd103, ADDR_HI, ADDR_LO, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, tct_pkg::PH_SYN_ACK},
    '{32'd104, ADDR_LO, ADDR_HI, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, tct_pkg::PH_ESTAB},
    '{32'd105, ADDR_LO, ADDR_HI, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, tct_pkg::PH_ESTAB},
    // Refresh one second before expiry, then land exactly on the expiry time.
    '{32'd283, ADDR_LO, ADDR_HI, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, tct_pkg::PH_ESTAB},
    '{32'd463, ADDR_LO, ADDR_HI, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, tct_pkg::PH_ESTAB},
    // Reuse of an expired entry keeps the server address.
    '{32'd464, ADDR_LO, ADDR_LO, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, tct_pkg::PH_SYN_SENT},
    '{32'd465, ADDR_HI, ADDR_LO, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, tct_pkg::PH_NONE},
    '{32'd466, ADDR_LO, ADDR_HI, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, tct_pkg::PH_NONE},
    // FIN starts closing; closing needs ACK or FIN; closing expires too.
    '{32'd500, ADDR_LO, ADDR_HI, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, tct_pkg::PH_CLOSING},
    '{32'd501, ADDR_LO, ADDR_HI, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, tct_pkg::PH_CLOSING},
    '{32'd505, ADDR_LO, ADDR_HI, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, tct_pkg::PH_CLOSING},
    '{32'd506, ADDR_LO, ADDR_LO, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, tct_pkg::PH_CLOSING},
    // Plain SYN with FIN at the top of time: the new expiry wraps to 4.
    '{ADDR_HI, ADDR_LO, ADDR_HI, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, tct_pkg::PH_SYN_SENT},
    '{32'd3, ADDR_HI, ADDR_LO, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, tct_pkg::PH_NONE},
    // All flags at once: reset wins.
    '{ADDR_HI, ADDR_HI, ADDR_LO, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, tct_pkg::PH_CLOSING},
    '{32'd0, ADDR_LO, ADDR_LO, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, tct_pkg::PH_SYN_SENT},
    // Unsigned compare: a huge time is past an expiry of 5.
    '{ADDR_HI, ADDR_HI, ADDR_LO, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, tct_pkg::PH_SYN_SENT}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [tct_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [tct_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  // Low bit up: now_seconds, source_addr, dest_addr, syn, ack, fin, rst, zero pad.
  logic [tct_pkg::IN_TDATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  // Low bit up: drop, state_after[2:0], zero pad.
  logic [tct_pkg::OUT_TDATA_W-1:0] out_tdata;

  // Tracker copy kept by the testbench.
  tct_pkg::phase_t model_phase = tct_pkg::PH_NONE;
  logic [tct_pkg::TIME_W-1:0] model_expiry = '0;
  logic [tct_pkg::ADDR_W-1:0] model_server = '0;
  logic [tct_pkg::CFG_DATA_W-1:0] hs_timeout = tct_pkg::HANDSHAKE_TIMEOUT_RST;
  logic [tct_pkg::CFG_DATA_W-1:0] est_timeout = tct_pkg::ESTABLISHED_TIMEOUT_RST;

  verdict_t pending_verdicts[$];
  given_verdict_t table_verdicts[$];
  logic [tct_pkg::TIME_W-1:0] stim_time = '0;
  logic bursty = 1'b1;
  int mismatch_count = 0;
  int cycle_count = 0;

  tcp_connection_state_tracker dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #2 clk = ~clk;

  // Watchdog over the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tcp_connection_state_tracker_tb: errors");
      $finish;
    end
  end

  function automatic logic [tct_pkg::IN_TDATA_W-1:0] pack_packet(input packet_t p);
    logic [tct_pkg::IN_TDATA_W-1:0] bus;
    bus = '0;
    bus[31:0] = p.now;
    bus[63:32] = p.src;
    bus[95:64] = p.dst;
    bus[96] = p.syn;
    bus[97] = p.ack;
    bus[98] = p.fin;
    bus[99] = p.rst;
    return bus;
  endfunction

  function automatic packet_t unpack_packet(input logic [tct_pkg::IN_TDATA_W-1:0] bus);
    packet_t p;
    p.now = bus[31:0];
    p.src = bus[63:32];
    p.dst = bus[95:64];
    p.syn = bus[96];
    p.ack = bus[97];
    p.fin = bus[98];
    p.rst = bus[99];
    return p;
  endfunction

  // Advances the connection entry by one packet and returns the decision.
  function automatic verdict_t track_packet(input packet_t p);
    verdict_t v;
    logic plain_syn;
    plain_syn = p.syn && !p.ack;
    v.drop = 1'b0;
    if (model_phase == tct_pkg::PH_NONE) begin
      if (plain_syn) begin
        model_phase = tct_pkg::PH_SYN_SENT;
        model_expiry = p.now + secs_t'(hs_timeout);
        model_server = p.dst;
      end else begin
        v.drop = 1'b1;
      end
    end else if (p.rst) begin
      model_phase = tct_pkg::PH_CLOSING;
      model_expiry = '0;
    end else begin
      if (model_phase != tct_pkg::PH_CLOSING && p.fin) begin
        model_phase = tct_pkg::PH_CLOSING;
        model_expiry = p.now + secs_t'(hs_timeout);
      end
      if (model_expiry <= p.now) begin
        // Only a plain SYN may take over an expired entry.
        if (plain_syn) begin
          model_phase = tct_pkg::PH_SYN_SENT;
          model_expiry = p.now + secs_t'(hs_timeout);
        end else begin
          v.drop = 1'b1;
        end
      end else begin
        case (model_phase)
          tct_pkg::PH_SYN_SENT: begin
            if (p.syn && p.ack && p.src == model_server) begin
              model_phase = tct_pkg::PH_SYN_ACK;
              model_expiry = p.now + secs_t'(hs_timeout);
            end else begin
              v.drop = 1'b1;
            end
          end
          tct_pkg::PH_SYN_ACK: begin
            if (p.syn) begin
              v.drop = 1'b1;
            end else begin
              model_phase = tct_pkg::PH_ESTAB;
              model_expiry = p.now + secs_t'(est_timeout);
            end
          end
          tct_pkg::PH_ESTAB: begin
            if (p.syn) v.drop = 1'b1;
            else model_expiry = p.now + secs_t'(est_timeout);
          end
          tct_pkg::PH_CLOSING: begin
            if (!p.ack && !p.fin) v.drop = 1'b1;
          end
          default: ;
        endcase
      end
    end
    v.state = 3'(model_phase);
    return v;
  endfunction

  // Mostly follows the handshake from the current phase; the rest is noise.
  function automatic packet_t next_packet();
    packet_t p;
    int unsigned roll;
    int unsigned span;
    span = 2 * ((hs_timeout > est_timeout) ? hs_timeout : est_timeout) + 2;
    roll = $urandom_range(0, 99);
    if (roll < 80) stim_time = stim_time + $urandom_range(0, 3);
    else if (roll < 93) stim_time = stim_time + $urandom_range(0, span);
    else if (roll < 97) stim_time = $urandom;
    else stim_time = ADDR_HI - $urandom_range(0, 6);
    p.now = stim_time;
    p.src = $urandom;
    p.dst = $urandom;
    p.syn = 1'b0;
    p.ack = 1'b0;
    p.fin = 1'b0;
    p.rst = 1'b0;
    roll = $urandom_range(0, 99);
    if (roll >= 75) begin
      {p.syn, p.ack, p.fin, p.rst} = 4'($urandom);
      if (roll >= 90) p.src = model_server;
    end else if (model_expiry <= p.now && roll < 50) begin
      // Reopen the expired entry.
      p.syn = 1'b1;
    end else begin
      case (model_phase)
        tct_pkg::PH_SYN_SENT: begin
          p.syn = 1'b1;
          p.ack = 1'b1;
          if ($urandom_range(0, 9) != 0) p.src = model_server;
        end
        tct_pkg::PH_SYN_ACK, tct_pkg::PH_ESTAB: begin
          p.ack = 1'b1;
          p.fin = ($urandom_range(0, 19) == 0);
          p.rst = ($urandom_range(0, 39) == 0);
        end
        tct_pkg::PH_CLOSING: begin
          if ($urandom_range(0, 2) == 0) begin
            p.syn = 1'b1;
          end else begin
            p.ack = 1'b1;
            p.fin = 1'($urandom_range(0, 1));
          end
        end
        default: p.syn = 1'b1;
      endcase
    end
    return p;
  endfunction

  task automatic report_mismatch(input string what, input logic [2:0] got_v,
                                 input logic [2:0] want_v);
    if (mismatch_count < 40)
      $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what,
               got_v, want_v);
    mismatch_count = mismatch_count + 1;
  endtask

  // Config writes, packet transfers and result transfers all seen at one edge.
  always @(posedge clk) begin : scoreboard
    packet_t pkt;
    verdict_t want;
    verdict_t got;
    given_verdict_t hint;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          tct_pkg::REG_HANDSHAKE_TIMEOUT: hs_timeout = cfg_data;
          tct_pkg::REG_ESTABLISHED_TIMEOUT: est_timeout = cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        pkt = unpack_packet(in_tdata);
        want = track_packet(pkt);
        hint = table_verdicts.pop_front();
        if (hint.known) begin
          want.drop = hint.drop;
          want.state = 3'(hint.state);
        end
        pending_verdicts.push_back(want);
      end
      if (out_tvalid && out_tready) begin
        got.drop = out_tdata[0];
        got.state = out_tdata[3:1];
        if (pending_verdicts.size() == 0) begin
          report_mismatch("result transfer with nothing pending, state", got.state, 3'd0);
        end else begin
          want = pending_verdicts.pop_front();
          if (got.drop !== want.drop) report_mismatch("drop", 3'(got.drop), 3'(want.drop));
          if (got.state !== want.state) report_mismatch("state_after", got.state, want.state);
        end
      end
    end
  end

  // Result side back-pressure in random bursts.
  always begin
    @(negedge clk);
    if (bursty && $urandom_range(0, 7) == 0) begin
      out_tready <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    out_tready <= 1'b1;
  end

  // Holds one packet on the bus until it is taken; returns at a falling edge.
  task automatic send_packet(input packet_t p, input given_verdict_t hint);
    if (bursty && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    table_verdicts.push_back(hint);
    in_tvalid <= 1'b1;
    in_tdata <= pack_packet(p);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Leaves cfg_valid high; the caller lowers it after its last write.
  task automatic write_register(input logic [tct_pkg::CFG_INDEX_W-1:0] idx,
                                input logic [tct_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Stops sending and waits until every pending result has arrived.
  task automatic wait_until_drained();
    in_tvalid <= 1'b0;
    while (pending_verdicts.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin : stimulus
    directed_row_t row;
    packet_t p;
    given_verdict_t hint;
    given_verdict_t no_hint;
    logic [tct_pkg::CFG_DATA_W-1:0] hs_pick;
    logic [tct_pkg::CFG_DATA_W-1:0] est_pick;
    no_hint = '{known: 1'b0, drop: 1'b0, state: tct_pkg::PH_NONE};
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed table with the reset timeouts.
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      row = DIRECTED[i];
      p = '{now: row.now, src: row.src, dst: row.dst, syn: row.syn, ack: row.ack,
            fin: row.fin, rst: row.rst};
      hint = '{known: row.known, drop: row.drop, state: row.state};
      send_packet(p, hint);
    end

    // Random traffic under several timeout settings; the last one runs without gaps.
    for (int s = 0; s < 6; s++) begin
      wait_until_drained();
      bursty = (s != 5);
      case (s)
        0: begin
          hs_pick = tct_pkg::HANDSHAKE_TIMEOUT_RST;
          est_pick = tct_pkg::ESTABLISHED_TIMEOUT_RST;
        end
        1: begin hs_pick = '0; est_pick = '0; end
        2: begin hs_pick = '1; est_pick = '1; end
        3: begin hs_pick = 16'd2; est_pick = 16'd9; end
        4: begin
          hs_pick = cfg_data_t'($urandom_range(1, 8));
          est_pick = cfg_data_t'($urandom_range(5, 40));
        end
        default: begin
          hs_pick = tct_pkg::HANDSHAKE_TIMEOUT_RST;
          est_pick = tct_pkg::ESTABLISHED_TIMEOUT_RST;
        end
      endcase
      write_register(tct_pkg::REG_HANDSHAKE_TIMEOUT, hs_pick);
      write_register(tct_pkg::REG_ESTABLISHED_TIMEOUT, est_pick);
      // A write to an unused index must leave both timeouts alone.
      write_register(cfg_index_t'($urandom_range(2, 255)), cfg_data_t'($urandom));
      cfg_valid <= 1'b0;
      repeat (ITEMS_PER_SETTING) send_packet(next_packet(), no_hint);
    end

    wait_until_drained();
    repeat (8) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("tcp_connection_state_tracker_tb: clean");
    end else begin
      $display("tcp_connection_state_tracker_tb: errors");
    end
    $finish;
  end

endmodule

// File: tcp_connection_state_tracker.f
hw/rtl/tct_pkg.sv
hw/rtl/tct_front.sv
hw/rtl/tct_queue.sv
hw/rtl/tct_back.sv
hw/rtl/tcp_connection_state_tracker.sv
dv/tcp_connection_state_tracker_tb.sv
